// ===== rtl/aas_pkg.sv =====
// aas_pkg: shared widths, register indexes, reset values and sequencer states
// for the adc averaging and smoothing block. No dependencies.
`default_nettype none

package aas_pkg;

  // payload field widths
  localparam int CHAN_W     = 3;
  localparam int SAMPLE_W   = 10;
  localparam int MEAN_W     = 10;
  localparam int VOLT_W     = 21;
  localparam int VREF_W     = 13;
  localparam int KEEP_W     = 8;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTH_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VREF_MV       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WEIGHT   = 2'd2;

  localparam logic              SMOOTH_RST = 1'b0;
  localparam logic [VREF_W-1:0] VREF_RST   = 13'd3300;
  localparam logic [KEEP_W-1:0] KEEP_RST   = 8'd26;

  // parameter defaults
  localparam int SAMPLES_PER_MEAN_DEF = 16;
  localparam int NUM_CHANNELS_DEF     = 8;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_QEST,
    ST_CORR,
    ST_PLAIN,
    ST_SMA,
    ST_SMB,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/aas_in_if.sv =====
// aas_in_if: sample request channel (valid/ready, channel and raw sample).
// Depends on aas_pkg for field widths.
`default_nettype none

interface aas_in_if;
  logic                         valid;
  logic                         ready;
  logic [aas_pkg::CHAN_W-1:0]   channel;
  logic [aas_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink   (input valid, input channel, input sample, output ready);
endinterface

`default_nettype wire

// ===== rtl/aas_out_if.sv =====
// aas_out_if: result request channel (valid/ready, channel, mean, voltage).
// Depends on aas_pkg for field widths.
`default_nettype none

interface aas_out_if;
  logic                       valid;
  logic                       ready;
  logic [aas_pkg::CHAN_W-1:0] out_channel;
  logic [aas_pkg::MEAN_W-1:0] mean_code;
  logic [aas_pkg::VOLT_W-1:0] voltage_q8_mv;

  modport source (output valid, output out_channel, output mean_code,
                  output voltage_q8_mv, input ready);
  modport sink   (input valid, input out_channel, input mean_code,
                  input voltage_q8_mv, output ready);
endinterface

`default_nettype wire

// ===== rtl/aas_cfg_if.sv =====
// aas_cfg_if: configuration write channel (valid/ready, register index, data).
// Depends on aas_pkg for index and data widths.
`default_nettype none

interface aas_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [aas_pkg::CFG_IDX_W-1:0]  index;
  logic [aas_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/adc_average_and_smooth.sv =====
// adc_average_and_smooth: per-channel boxcar average with optional exponential
// smoothing of the voltage. Depends on aas_pkg, aas_in_if, aas_out_if, aas_cfg_if.
//
// Usage:
//   in_bus  : sample requests (channel, 10-bit sample). A channel at or above
//             NUM_CHANNELS is accepted and dropped without effect.
//   out_bus : one result per SAMPLES_PER_MEAN samples of a channel: channel,
//             rounded mean and voltage in mV with 8 fraction bits.
//   cfg_bus : register writes, always ready (0 smooth_enable, 1 vref_mv,
//             2 keep_weight, index 3 ignored); write only while idle.
// Timing: per-channel sum, count and held voltage live in one memory with a
//   registered read. A sample that does not complete a block takes a read
//   step, then an update and write back step, and no new request is taken
//   until it is written back. A completing sample steps through read,
//   reciprocal multiply, quotient correction, vref multiply, two blend
//   multiplies when smoothing is on, then result load and write back. Out
//   valid rises from the result load step, once the output register is free.
// Reset: clears the registers to their defaults and marks every memory entry
//   empty; an empty entry reads as zero. No clearing pass is needed.
// Stall: a finished result sits in the output register while further samples
//   are taken; the next completing block waits in its last step until the
//   output register is free.
`default_nettype none

module adc_average_and_smooth #(
  parameter int SAMPLES_PER_MEAN = aas_pkg::SAMPLES_PER_MEAN_DEF,
  parameter int NUM_CHANNELS     = aas_pkg::NUM_CHANNELS_DEF
) (
  input  wire           clk,
  input  wire           rst_n,
  aas_in_if.sink        in_bus,
  aas_out_if.source     out_bus,
  aas_cfg_if.sink       cfg_bus
);

  localparam int CHAN_W   = aas_pkg::CHAN_W;
  localparam int SAMPLE_W = aas_pkg::SAMPLE_W;
  localparam int MEAN_W   = aas_pkg::MEAN_W;
  localparam int VOLT_W   = aas_pkg::VOLT_W;
  localparam int VREF_W   = aas_pkg::VREF_W;
  localparam int KEEP_W   = aas_pkg::KEEP_W;

  localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SUM_MAX = ((1 << SAMPLE_W) - 1) * SAMPLES_PER_MEAN;
  localparam int SUM_W   = $clog2(SUM_MAX + 1);
  localparam int CNT_W   = $clog2(SAMPLES_PER_MEAN + 1);
  localparam int WORD_W  = VOLT_W + CNT_W + SUM_W;

  // mean = floor((2*sum + N) / (2*N)) via reciprocal multiply and one fixup
  localparam int DIV_D  = 2 * SAMPLES_PER_MEAN;
  localparam int NUM_W  = $clog2(2 * SUM_MAX + SAMPLES_PER_MEAN + 1);
  localparam int REC_K  = NUM_W;
  localparam int PROD_W = NUM_W + REC_K;

  localparam logic [REC_K-1:0]  REC_M    = REC_K'((1 << REC_K) / DIV_D);
  localparam logic [NUM_W-1:0]  DIV_L    = NUM_W'(DIV_D);
  localparam logic [NUM_W-1:0]  HALF_L   = NUM_W'(SAMPLES_PER_MEAN);
  localparam logic [NUM_W-1:0]  MEAN_MAX = NUM_W'((1 << MEAN_W) - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(SAMPLES_PER_MEAN);
  localparam logic [CHAN_W+1:0] NUM_CH_L = (CHAN_W + 2)'(NUM_CHANNELS);

  localparam int MV_W  = MEAN_W + VREF_W;
  localparam int BLD_W = KEEP_W + VOLT_W + 1;

  // configuration registers
  logic              smooth_r;
  logic [VREF_W-1:0] vref_r;
  logic [KEEP_W-1:0] keep_r;

  // sequencer
  aas_pkg::state_t state_r, state_nxt;

  // datapath registers
  logic [CH_AW-1:0]    addr_r;
  logic [CHAN_W-1:0]   ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic [VOLT_W-1:0]   held_r;
  logic [NUM_W-1:0]    num_r;
  logic [NUM_W-1:0]    q_r;
  logic [MEAN_W-1:0]   mean_r;
  logic [VOLT_W-1:0]   plain_r;
  logic [BLD_W-2:0]    prod_a_r;
  logic [VOLT_W-1:0]   volt_r;

  // output register
  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic [MEAN_W-1:0] out_mean_r;
  logic [VOLT_W-1:0] out_volt_r;

  // channel memory and per-entry valid bits
  logic [WORD_W-1:0]       mem_r [NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] vld_r;
  logic [WORD_W-1:0]       rd_word_r;
  logic                    rd_vld_r;

  // control
  logic              in_acc;
  logic              ch_ok;
  logic [CH_AW-1:0]  in_addr;
  logic              mem_re;
  logic              mem_we;
  logic              out_load;
  logic              out_free;
  logic [WORD_W-1:0] mem_wdata;

  // datapath combinational values
  logic [SUM_W-1:0]  cur_sum;
  logic [CNT_W-1:0]  cur_cnt;
  logic [VOLT_W-1:0] cur_held;
  logic [SUM_W-1:0]  sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic              blk_done;
  logic [NUM_W-1:0]  num_nxt;
  logic [PROD_W-1:0] qest_prod;
  logic [NUM_W-1:0]  qd_prod;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  q_fix;
  logic [MEAN_W-1:0] mean_nxt;
  logic [MV_W-1:0]   mv_prod;
  logic [BLD_W-2:0]  prod_a;
  logic [KEEP_W:0]   keep_c;
  logic [BLD_W-1:0]  prod_b;
  logic [BLD_W-1:0]  blend;

  // input request decode
  assign in_acc  = in_bus.valid && in_bus.ready;
  assign ch_ok   = {2'b00, in_bus.channel} < NUM_CH_L;
  assign in_addr = CH_AW'(in_bus.channel);
  assign out_free = !out_valid_r || out_bus.ready;

  // configuration writes
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smooth_r <= aas_pkg::SMOOTH_RST;
      vref_r   <= aas_pkg::VREF_RST;
      keep_r   <= aas_pkg::KEEP_RST;
    end else if (cfg_bus.valid && cfg_bus.ready) begin
      unique case (cfg_bus.index)
        aas_pkg::CFG_SMOOTH_ENABLE: smooth_r <= cfg_bus.data[0];
        aas_pkg::CFG_VREF_MV:       vref_r   <= cfg_bus.data[VREF_W-1:0];
        aas_pkg::CFG_KEEP_WEIGHT:   keep_r   <= cfg_bus.data[KEEP_W-1:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aas_pkg::ST_IDLE:  if (in_acc && ch_ok) state_nxt = aas_pkg::ST_READ;
      aas_pkg::ST_READ:  state_nxt = blk_done ? aas_pkg::ST_QEST : aas_pkg::ST_IDLE;
      aas_pkg::ST_QEST:  state_nxt = aas_pkg::ST_CORR;
      aas_pkg::ST_CORR:  state_nxt = aas_pkg::ST_PLAIN;
      aas_pkg::ST_PLAIN: state_nxt = smooth_r ? aas_pkg::ST_SMA : aas_pkg::ST_EMIT;
      aas_pkg::ST_SMA:   state_nxt = aas_pkg::ST_SMB;
      aas_pkg::ST_SMB:   state_nxt = aas_pkg::ST_EMIT;
      aas_pkg::ST_EMIT:  if (out_free) state_nxt = aas_pkg::ST_IDLE;
      default:           state_nxt = aas_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_bus.ready = 1'b0;
    mem_re       = 1'b0;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      aas_pkg::ST_IDLE: begin
        in_bus.ready = 1'b1;
        mem_re       = in_bus.valid && ch_ok;
      end
      aas_pkg::ST_READ: mem_we = !blk_done;
      aas_pkg::ST_EMIT: begin
        mem_we   = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= aas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // memory entry as read, empty entries count as zero
  assign cur_sum  = rd_vld_r ? rd_word_r[SUM_W-1:0] : '0;
  assign cur_cnt  = rd_vld_r ? rd_word_r[SUM_W +: CNT_W] : '0;
  assign cur_held = rd_vld_r ? rd_word_r[SUM_W + CNT_W +: VOLT_W] : '0;

  // accumulate
  assign sum_new  = cur_sum + SUM_W'(sample_r);
  assign cnt_new  = cur_cnt + CNT_W'(1);
  assign blk_done = cnt_new >= CNT_FULL;
  assign num_nxt  = NUM_W'({sum_new, 1'b0}) + HALF_L;

  // quotient estimate and correction
  assign qest_prod = PROD_W'(num_r) * PROD_W'(REC_M);
  assign qd_prod   = q_r * DIV_L;
  assign rem       = num_r - qd_prod;
  assign q_fix     = (rem >= DIV_L) ? q_r + NUM_W'(1) : q_r;
  assign mean_nxt  = (q_fix > MEAN_MAX) ? MEAN_MAX[MEAN_W-1:0] : q_fix[MEAN_W-1:0];

  // voltage and blend
  assign mv_prod = MV_W'(mean_r) * MV_W'(vref_r);
  assign prod_a  = (BLD_W - 1)'(keep_r) * (BLD_W - 1)'(held_r);
  assign keep_c  = (KEEP_W + 1)'(1 << KEEP_W) - (KEEP_W + 1)'(keep_r);
  assign prod_b  = BLD_W'(keep_c) * BLD_W'(plain_r);
  assign blend   = BLD_W'(prod_a_r) + prod_b;

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc && ch_ok) begin
      addr_r   <= in_addr;
      ch_r     <= in_bus.channel;
      sample_r <= in_bus.sample;
    end
    if (state_r == aas_pkg::ST_READ) begin
      num_r  <= num_nxt;
      held_r <= cur_held;
    end
    if (state_r == aas_pkg::ST_QEST) begin
      q_r <= qest_prod[PROD_W-1:REC_K];
    end
    if (state_r == aas_pkg::ST_CORR) begin
      mean_r <= mean_nxt;
    end
    if (state_r == aas_pkg::ST_PLAIN) begin
      plain_r <= mv_prod[MV_W-1:2];
      volt_r  <= mv_prod[MV_W-1:2];
    end
    if (state_r == aas_pkg::ST_SMA) begin
      prod_a_r <= prod_a;
    end
    if (state_r == aas_pkg::ST_SMB) begin
      volt_r <= blend[KEEP_W +: VOLT_W];
    end
  end

  // write back: accumulate, or clear sum and count and hold the voltage
  assign mem_wdata = (state_r == aas_pkg::ST_EMIT) ?
                     {volt_r, {CNT_W{1'b0}}, {SUM_W{1'b0}}} :
                     {cur_held, cnt_new, sum_new};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[addr_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_word_r <= mem_r[in_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[addr_r] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_r <= vld_r[in_addr];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_chan_r <= ch_r;
      out_mean_r <= mean_r;
      out_volt_r <= volt_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_channel   = out_chan_r;
  assign out_bus.mean_code     = out_mean_r;
  assign out_bus.voltage_q8_mv = out_volt_r;

  // memory read and write never share a cycle
  a_rw_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_re && mem_we))
    else $error("channel memory read and write in the same cycle");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_bus.ready) |=> (out_chan_r == $past(out_chan_r)
      && out_volt_r == $past(out_volt_r) && out_mean_r == $past(out_mean_r)))
    else $error("pending result overwritten");

  // a stored count stays below the block length
  a_cnt_below_full: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (mem_wdata[SUM_W +: CNT_W] < CNT_FULL))
    else $error("stored sample count reached block length");

  // a new result only comes out of the emit step
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == aas_pkg::ST_EMIT))
    else $error("result raised outside the emit step");

endmodule

`default_nettype wire

// ===== verif/adc_average_and_smooth_tb.sv =====
// adc_average_and_smooth_tb: self-checking bench for the adc averaging and smoothing block.
// A per-channel block model predicts every mean and voltage; depends on aas_pkg,
// aas_in_if, aas_out_if, aas_cfg_if and adc_average_and_smooth.

module adc_average_and_smooth_tb;

  localparam int BLOCK_LEN     = aas_pkg::SAMPLES_PER_MEAN_DEF;
  localparam int CHANNELS      = aas_pkg::NUM_CHANNELS_DEF;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  // register index with no register behind it
  localparam logic [aas_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [aas_pkg::CHAN_W-1:0] chan;
    logic [aas_pkg::MEAN_W-1:0] mean;
    logic [aas_pkg::VOLT_W-1:0] volt;
  } block_result_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  aas_in_if  in_bus ();
  aas_out_if out_bus ();
  aas_cfg_if cfg_bus ();

  adc_average_and_smooth dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always #1 clk = ~clk;

  // channel model state and register copies
  longint unsigned acc_sum   [CHANNELS];
  longint unsigned acc_count [CHANNELS];
  longint unsigned held_mv   [CHANNELS];
  longint unsigned smooth_on;
  longint unsigned vref_mv;
  longint unsigned keep_q8;

  block_result_t pending_results [$];
  int mismatch_count = 0;
  int idle_cycles    = 0;
  int stall_left     = 0;
  bit no_idling      = 1'b0;

  // fold one accepted sample into its channel, queue a result on a full block
  task automatic absorb_sample(input logic [aas_pkg::CHAN_W-1:0] chan,
                               input logic [aas_pkg::SAMPLE_W-1:0] code);
    longint unsigned mean;
    longint unsigned plain;
    longint unsigned volt;
    block_result_t res;
    if (chan >= CHANNELS) return;
    acc_sum[chan]   = acc_sum[chan] + code;
    acc_count[chan] = acc_count[chan] + 1;
    if (acc_count[chan] < BLOCK_LEN) return;
    // rounded half up
    mean = (2 * acc_sum[chan] + BLOCK_LEN) / (2 * BLOCK_LEN);
    if (mean > 1023) mean = 1023;
    plain = (mean * vref_mv) >> 2;
    if (smooth_on != 0) begin
      volt = (keep_q8 * held_mv[chan] + (256 - keep_q8) * plain) >> 8;
    end else begin
      volt = plain;
    end
    volt = volt & 64'h1F_FFFF;
    held_mv[chan]   = volt;
    acc_sum[chan]   = 0;
    acc_count[chan] = 0;
    res.chan = chan;
    res.mean = mean[aas_pkg::MEAN_W-1:0];
    res.volt = volt[aas_pkg::VOLT_W-1:0];
    pending_results.push_back(res);
  endtask

  task automatic flag_mismatch(input string what, input longint unsigned want,
                               input longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $time);
  endtask

  // compare each result request with the oldest prediction
  always @(posedge clk) begin : result_check
    block_result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("result with nothing pending: channel %0d mean %0d voltage %0d at %0t",
                   out_bus.out_channel, out_bus.mean_code, out_bus.voltage_q8_mv, $time);
      end else begin
        want = pending_results.pop_front();
        if (out_bus.out_channel !== want.chan)
          flag_mismatch("out_channel", want.chan, out_bus.out_channel);
        if (out_bus.mean_code !== want.mean)
          flag_mismatch("mean_code", want.mean, out_bus.mean_code);
        if (out_bus.voltage_q8_mv !== want.volt)
          flag_mismatch("voltage_q8_mv", want.volt, out_bus.voltage_q8_mv);
      end
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (no_idling) begin
      out_bus.ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_bus.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 11) == 0) begin
      out_bus.ready <= 1'b0;
      stall_left = $urandom_range(1, 19) - 1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  // count cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("== FAIL ==");
    $finish;
  end

  // one sample request, with an optional sender gap in front
  task automatic send_sample(input logic [aas_pkg::CHAN_W-1:0] chan,
                             input logic [aas_pkg::SAMPLE_W-1:0] code);
    int gap;
    gap = 0;
    if (!no_idling && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.channel <= chan;
    in_bus.sample  <= code;
    do @(posedge clk); while (!in_bus.ready);
    absorb_sample(chan, code);
    @(negedge clk);
  endtask

  // random samples on channels 0..top_chan, biased toward the code extremes
  task automatic send_random(input int count, input int top_chan);
    logic [aas_pkg::SAMPLE_W-1:0] code;
    repeat (count) begin
      case ($urandom_range(0, 7))
        0:       code = '0;
        1:       code = '1;
        default: code = aas_pkg::SAMPLE_W'($urandom);
      endcase
      send_sample(aas_pkg::CHAN_W'($urandom_range(0, top_chan)), code);
    end
  endtask

  // stop sending, wait for every pending result, then let the block go quiet
  task automatic settle_block();
    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [aas_pkg::CFG_IDX_W-1:0] idx,
                           input logic [aas_pkg::CFG_DATA_W-1:0] data);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      aas_pkg::CFG_SMOOTH_ENABLE: smooth_on = data[0];
      aas_pkg::CFG_VREF_MV:       vref_mv   = data;
      aas_pkg::CFG_KEEP_WEIGHT:   keep_q8   = data[aas_pkg::KEEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [aas_pkg::CFG_DATA_W-1:0] smooth,
                            input logic [aas_pkg::CFG_DATA_W-1:0] vref,
                            input logic [aas_pkg::CFG_DATA_W-1:0] keep);
    write_reg(aas_pkg::CFG_SMOOTH_ENABLE, smooth);
    write_reg(aas_pkg::CFG_VREF_MV, vref);
    write_reg(aas_pkg::CFG_KEEP_WEIGHT, keep);
  endtask

  // full-scale block on the top channel with reset register values
  task automatic test_full_scale();
    repeat (BLOCK_LEN) send_sample(aas_pkg::CHAN_W'(CHANNELS - 1), '1);
    settle_block();
  endtask

  // random traffic before any register write
  task automatic test_reset_values();
    send_random(150, CHANNELS - 1);
    settle_block();
  endtask

  // largest reference, traffic on two channels for frequent results
  task automatic test_large_reference();
    set_config(13'd0, 13'h1FFF, 13'd0);
    send_random(150, 1);
    settle_block();
  endtask

  // smoothing at both weight extremes and at random weights
  task automatic test_smoothing();
    set_config(13'd1, 13'd5000, 13'd0);
    send_random(120, 3);
    settle_block();
    write_reg(aas_pkg::CFG_KEEP_WEIGHT, 13'd255);
    send_random(120, CHANNELS - 1);
    settle_block();
    set_config(13'd1, aas_pkg::CFG_DATA_W'($urandom_range(1, 5000)),
               aas_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    send_random(120, 2);
    settle_block();
  endtask

  // smoothing switched off and on again blends with the last voltage sent
  task automatic test_smoothing_toggle();
    set_config(13'd0, 13'd2500, 13'd200);
    send_random(50, 1);
    settle_block();
    write_reg(aas_pkg::CFG_SMOOTH_ENABLE, 13'd1);
    send_random(50, 1);
    settle_block();
    write_reg(aas_pkg::CFG_SMOOTH_ENABLE, 13'd0);
    send_random(50, 1);
    settle_block();
  endtask

  // zero reference drives the plain voltage to zero, smoothing decays the old one
  task automatic test_zero_reference();
    set_config(13'd1, 13'd0, 13'd128);
    send_random(120, 3);
    settle_block();
  endtask

  // unused index is dropped, data bits above each register width are dropped
  task automatic test_ignored_register();
    write_reg(CFG_UNUSED, aas_pkg::CFG_DATA_W'($urandom));
    set_config(13'h1FFF, 13'd1, 13'h1FFF);
    write_reg(CFG_UNUSED, '1);
    send_random(60, 1);
    settle_block();
    write_reg(aas_pkg::CFG_SMOOTH_ENABLE, 13'h1FFE);
    write_reg(aas_pkg::CFG_KEEP_WEIGHT, 13'h1F00);
    send_random(60, 1);
    settle_block();
  endtask

  // sender holds off until every pending result has come back
  task automatic test_pause_for_results();
    set_config(13'd1, aas_pkg::CFG_DATA_W'($urandom_range(1, 5000)),
               aas_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    repeat (6) begin
      send_random(24, $urandom_range(0, CHANNELS - 1));
      settle_block();
    end
  endtask

  // back-to-back traffic with no gaps or stalls on either side
  task automatic test_no_idling();
    set_config(aas_pkg::CFG_DATA_W'($urandom_range(0, 1)),
               aas_pkg::CFG_DATA_W'($urandom_range(1, 5000)),
               aas_pkg::CFG_DATA_W'($urandom_range(0, 255)));
    no_idling = 1'b1;
    send_random(250, CHANNELS - 1);
    settle_block();
  endtask

  initial begin
    in_bus.valid   = 1'b0;
    in_bus.channel = '0;
    in_bus.sample  = '0;
    cfg_bus.valid  = 1'b0;
    cfg_bus.index  = '0;
    cfg_bus.data   = '0;
    out_bus.ready  = 1'b0;
    smooth_on = aas_pkg::SMOOTH_RST;
    vref_mv   = aas_pkg::VREF_RST;
    keep_q8   = aas_pkg::KEEP_RST;
    for (int i = 0; i < CHANNELS; i++) begin
      acc_sum[i]   = 0;
      acc_count[i] = 0;
      held_mv[i]   = 0;
    end
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_full_scale();
    test_reset_values();
    test_large_reference();
    test_smoothing();
    test_smoothing_toggle();
    test_zero_reference();
    test_ignored_register();
    test_pause_for_results();
    test_no_idling();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
